// ----- hdl/lidar_point_projector_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the lidar point projector
// Immediate-style wrappers around concurrent checks on clk, masked in reset.
// ---------------------------------------------------------------------------
`ifndef LIDAR_POINT_PROJECTOR_MACROS_SVH
`define LIDAR_POINT_PROJECTOR_MACROS_SVH

// same-cycle check
`define LPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define LPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/lpp_pkg.sv -----
// ---------------------------------------------------------------------------
// Lidar point projector package
// Field widths, register map and default fixed-point formats.
// ---------------------------------------------------------------------------
package lpp_pkg;

  localparam int COORD_FRAC_BITS_DFLT = 8;
  localparam int COEF_FRAC_BITS_DFLT  = 16;

  localparam int COORD_W = 24;
  localparam int COEF_W  = 32;
  localparam int PIX_W   = 24;
  localparam int DEP_W   = 32;
  localparam int SIZE_W  = 14;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 6;

  localparam logic [2:0] REG_ROW0_AB = 3'd0;
  localparam logic [2:0] REG_ROW0_CD = 3'd1;
  localparam logic [2:0] REG_ROW1_AB = 3'd2;
  localparam logic [2:0] REG_ROW1_CD = 3'd3;
  localparam logic [2:0] REG_ROW2_AB = 3'd4;
  localparam logic [2:0] REG_ROW2_CD = 3'd5;
  localparam logic [2:0] REG_WIDTH   = 3'd6;
  localparam logic [2:0] REG_HEIGHT  = 3'd7;

endpackage

// ----- hdl/lidar_point_projector.sv -----
// ---------------------------------------------------------------------------
// Lidar point projector
// Projects (x,y,z) through a 3x4 matrix, divides by the third row, filters.
// ---------------------------------------------------------------------------
// One point is taken per clock cycle while the output is not stalled, and
// results leave in order through one multiply stage, one row-sum stage, one
// setup stage, one stage per quotient bit of the two parallel restoring
// dividers for u and v, and the output register. Points rejected by the image
// bounds or depth test leave no beat. A stalled output freezes the whole pipe,
// and s_tready drops with it. Coefficients live at byte address 8*i, one
// 64-bit word per register.
`include "lidar_point_projector_macros.svh"

module lidar_point_projector import lpp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DFLT,
  parameter int COEF_FRAC_BITS  = COEF_FRAC_BITS_DFLT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [71:0]       s_tdata,   // point_x, point_y, point_z
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,   // pixel_u, pixel_v, depth
  output logic [1:0]        m_tuser,   // behind_sensor, saturated
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int PROD_W = COORD_W + COEF_W;
  localparam int K_W    = COEF_W + COORD_FRAC_BITS;
  localparam int SUM_W  = ((PROD_W > K_W) ? PROD_W : K_W) + 2;
  localparam int MAG_W  = SUM_W;
  localparam int QW     = PIX_W + COORD_FRAC_BITS;

  localparam logic [QW-1:0]    PIX_POS_MAX = QW'((64'd1 << (PIX_W - 1)) - 64'd1);
  localparam logic [QW-1:0]    PIX_NEG_MAG = QW'(64'd1 << (PIX_W - 1));
  localparam logic [MAG_W-1:0] DEP_POS_MAX = MAG_W'((64'd1 << (DEP_W - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] DEP_NEG_MAG = MAG_W'(64'd1 << (DEP_W - 1));

  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic [1:0]       neg;
    logic [1:0]       ovf;
    logic [1:0]       nzero;
    logic [1:0]       nonneg;
    logic             den_pos;
    logic [DEP_W-1:0] dep;
    logic             dep_sat;
    logic             behind;
  } side_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0]  coef [0:5];
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  logic [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      image_width  <= '0;
      image_height <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default:    coef[cfg_idx] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIDTH:  prdata = CFG_W'(image_width);
      REG_HEIGHT: prdata = CFG_W'(image_height);
      default:    prdata = coef[cfg_idx];
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: products ----------------
  logic signed [COORD_W-1:0] pt [0:2];
  logic signed [PROD_W-1:0]  prod [0:2][0:2];
  logic signed [K_W-1:0]     kcol [0:2];
  logic                      v1;

  assign pt[0] = s_tdata[23:0];
  assign pt[1] = s_tdata[47:24];
  assign pt[2] = s_tdata[71:48];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= PROD_W'($signed(coef[2*r][31:0]))   * PROD_W'(pt[0]);
        prod[r][1] <= PROD_W'($signed(coef[2*r][63:32]))  * PROD_W'(pt[1]);
        prod[r][2] <= PROD_W'($signed(coef[2*r+1][31:0])) * PROD_W'(pt[2]);
        kcol[r]    <= K_W'($signed(coef[2*r+1][63:32])) <<< COORD_FRAC_BITS;
      end
    end
  end

  // ---------------- stage 2: row sums ----------------
  logic signed [SUM_W-1:0] rsum [0:2];
  logic                    v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        rsum[r] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2])
                 + SUM_W'(kcol[r]);
      end
    end
  end

  // ---------------- stage 3: divider setup ----------------
  logic [MAG_W-1:0] nmag [0:1];
  logic [MAG_W-1:0] dmag;
  logic [MAG_W-1:0] dshift;
  side_t            side_in;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nmag[l] = rsum[l][SUM_W-1] ? MAG_W'(-rsum[l]) : MAG_W'(rsum[l]);
    end
    dmag   = rsum[2][SUM_W-1] ? MAG_W'(-rsum[2]) : MAG_W'(rsum[2]);
    dshift = dmag >> COEF_FRAC_BITS;
    side_in.den     = dmag;
    side_in.den_pos = !rsum[2][SUM_W-1] && (rsum[2] != '0);
    side_in.behind  = !side_in.den_pos;
    for (int l = 0; l < 2; l++) begin
      side_in.neg[l]    = rsum[l][SUM_W-1] ^ rsum[2][SUM_W-1];
      side_in.nzero[l]  = (rsum[l] != '0);
      side_in.nonneg[l] = !rsum[l][SUM_W-1];
      // quotient needs more than PIX_W integer bits, or the divisor is zero
      side_in.ovf[l]    = (nmag[l] >> PIX_W) >= dmag;
    end
    if (rsum[2][SUM_W-1]) begin
      side_in.dep_sat = dshift > DEP_NEG_MAG;
      side_in.dep     = side_in.dep_sat ? DEP_NEG_MAG[DEP_W-1:0]
                                        : DEP_W'(MAG_W'(0) - dshift);
    end else begin
      side_in.dep_sat = dshift > DEP_POS_MAX;
      side_in.dep     = side_in.dep_sat ? DEP_POS_MAX[DEP_W-1:0] : dshift[DEP_W-1:0];
    end
  end

  // ---------------- divider steps ----------------
  logic [MAG_W-1:0] drem [0:1][0:QW];
  logic [QW-1:0]    dlo  [0:1][0:QW];
  logic [QW-1:0]    dquo [0:1][0:QW];
  side_t            dside [0:QW];
  logic             dvld  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside[0] <= side_in;
      for (int l = 0; l < 2; l++) begin
        drem[l][0] <= nmag[l] >> PIX_W;
        dlo[l][0]  <= QW'(nmag[l][PIX_W-1:0]) << COORD_FRAC_BITS;
        dquo[l][0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MAG_W:0] trial [0:1];
    logic [1:0]     take;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {drem[l][k], dlo[l][k][QW-1]};
        take[l]  = trial[l] >= {1'b0, dside[k].den};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k+1] <= 1'b0;
      end else if (en) begin
        dvld[k+1] <= dvld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dside[k+1] <= dside[k];
        for (int l = 0; l < 2; l++) begin
          drem[l][k+1] <= take[l] ? MAG_W'(trial[l] - {1'b0, dside[k].den})
                                  : trial[l][MAG_W-1:0];
          dlo[l][k+1]  <= dlo[l][k] << 1;
          dquo[l][k+1] <= {dquo[l][k][QW-2:0], take[l]};
        end
      end
    end
  end

  // ---------------- output: saturate, filter ----------------
  logic [PIX_W-1:0] pix [0:1];
  logic [1:0]       pix_sat;
  logic [1:0]       in_box;
  logic [QW-1:0]    lim [0:1];
  logic             filt;
  logic             keep;
  side_t            fs;

  assign fs     = dside[QW];
  assign filt   = (image_width != '0) && (image_height != '0);
  assign lim[0] = QW'(image_width) << COORD_FRAC_BITS;
  assign lim[1] = QW'(image_height) << COORD_FRAC_BITS;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      in_box[l] = !fs.ovf[l] && ((dquo[l][QW] < lim[l]) ||
                  ((dquo[l][QW] == lim[l]) && (drem[l][QW] == '0)));
      if (!fs.nzero[l]) begin
        pix[l]     = '0;
        pix_sat[l] = 1'b0;
      end else if (fs.ovf[l]) begin
        pix_sat[l] = 1'b1;
        pix[l]     = fs.neg[l] ? PIX_NEG_MAG[PIX_W-1:0] : PIX_POS_MAX[PIX_W-1:0];
      end else if (fs.neg[l]) begin
        pix_sat[l] = dquo[l][QW] > PIX_NEG_MAG;
        pix[l]     = pix_sat[l] ? PIX_NEG_MAG[PIX_W-1:0]
                                : PIX_W'(QW'(0) - dquo[l][QW]);
      end else begin
        pix_sat[l] = dquo[l][QW] > PIX_POS_MAX;
        pix[l]     = pix_sat[l] ? PIX_POS_MAX[PIX_W-1:0] : dquo[l][QW][PIX_W-1:0];
      end
    end
    keep = !filt || (fs.den_pos && fs.nonneg[0] && fs.nonneg[1] && in_box[0] && in_box[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dvld[QW] && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {fs.dep, pix[1], pix[0]};
      m_tuser <= {pix_sat[0] || pix_sat[1] || fs.dep_sat, fs.behind};
    end
  end

  // ---------------- checks ----------------
  `LPP_ASSERT(a_ready_tracks_stall, s_tready == (!m_tvalid || m_tready), "ready does not follow output stall")
  `LPP_ASSERT(a_no_behind_filtered, !(m_tvalid && filt && m_tuser[0]), "behind-sensor point passed the filter")
  `LPP_ASSERT(a_pix_nonneg_filtered, !(m_tvalid && filt && (m_tdata[23] || m_tdata[47])), "negative pixel passed the filter")
  `LPP_ASSERT_NEXT(a_hold_frozen_pipe, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

// ----- tb/tb_lidar_point_projector.sv -----
// ---------------------------------------------------------------------------
// Lidar point projector testbench
// Drives points through the stream port under several matrix and image-size
// settings, predicts every projected beat and checks it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class projection_scoreboard;
  logic [63:0] coef_word[6];
  logic [13:0] img_w, img_h;
  logic [81:0] pending[$];
  int errors;

  function new();
    errors = 0;
    img_w = 0;
    img_h = 0;
    foreach (coef_word[i]) coef_word[i] = 0;
  endfunction

  function void set_reg(int idx, logic [63:0] value);
    if (idx < 6) coef_word[idx] = value;
    else if (idx == 6) img_w = value[13:0];
    else if (idx == 7) img_h = value[13:0];
  endfunction

  function longint row_total(int row, longint x, longint y, longint z);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(coef_word[row*2][31:0]));
    c1 = longint'($signed(coef_word[row*2][63:32]));
    c2 = longint'($signed(coef_word[row*2+1][31:0]));
    c3 = longint'($signed(coef_word[row*2+1][63:32]));
    return c0 * x + c1 * y + c2 * z + c3 * 256;
  endfunction

  // Clip a signed quotient or depth given sign and magnitude.
  function longint clamp(bit neg, logic [63:0] m, longint pmax, ref bit sat);
    if (neg) begin
      if (m > 64'(pmax) + 1) begin
        sat = 1;
        return -pmax - 1;
      end
      return -longint'(m);
    end
    if (m > 64'(pmax)) begin
      sat = 1;
      return pmax;
    end
    return longint'(m);
  endfunction

  function logic [63:0] absval(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function longint pixel_quot(longint num, longint den, ref bit sat);
    logic [63:0] n, d, q, r, m;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = absval(num);
    d = absval(den);
    if (n == 0) return 0;
    if (d == 0) return clamp(num < 0, '1, 8388607, sat);
    q = n / d;
    r = n % d;
    if (q >= 64'd16777216) return clamp(neg, '1, 8388607, sat);
    m = q << 8;
    for (int i = 7; i >= 0; i--) begin
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        m[i] = 1'b1;
      end
    end
    return clamp(neg, m, 8388607, sat);
  endfunction

  function bit fits(longint num, longint den, logic [13:0] lim);
    logic [63:0] q, r;
    q = 64'(num) / 64'(den);
    r = 64'(num) % 64'(den);
    return q < lim || (q == lim && r == 0);
  endfunction

  function void note_point(logic [71:0] pt);
    longint x, y, z, s0, s1, s2, u, v, dep;
    bit sat;
    x = longint'($signed(pt[23:0]));
    y = longint'($signed(pt[47:24]));
    z = longint'($signed(pt[71:48]));
    s0 = row_total(0, x, y, z);
    s1 = row_total(1, x, y, z);
    s2 = row_total(2, x, y, z);
    sat = 0;
    if (img_w != 0 && img_h != 0) begin
      if (s2 <= 0 || s0 < 0 || s1 < 0) return;
      if (!fits(s0, s2, img_w) || !fits(s1, s2, img_h)) return;
    end
    u = pixel_quot(s0, s2, sat);
    v = pixel_quot(s1, s2, sat);
    dep = clamp(s2 < 0, absval(s2) >> 16, 2147483647, sat);
    pending.insert(pending.size(), {sat, s2 <= 0, dep[31:0], v[23:0], u[23:0]});
  endfunction

  function void check_beat(logic [79:0] data, logic [1:0] user);
    logic [81:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat expected none actual %h/%b", $time, data, user);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (data[23:0] !== want[23:0]) begin
      $display("%0t: pixel_u expected %h actual %h", $time, want[23:0], data[23:0]);
      errors++;
    end
    if (data[47:24] !== want[47:24]) begin
      $display("%0t: pixel_v expected %h actual %h", $time, want[47:24], data[47:24]);
      errors++;
    end
    if (data[79:48] !== want[79:48]) begin
      $display("%0t: depth expected %h actual %h", $time, want[79:48], data[79:48]);
      errors++;
    end
    if (user !== want[81:80]) begin
      $display("%0t: flags expected %b actual %b", $time, want[81:80], user);
      errors++;
    end
  endfunction
endclass

module tb_lidar_point_projector;
  import lpp_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [79:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [CFG_W-1:0] pwdata = '0;
  logic [CFG_W-1:0] prdata;
  logic pready;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  projection_scoreboard board;

  lidar_point_projector dut (.*);

  always #5 clk = ~clk;

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_beat(m_tdata, m_tuser);
      m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, value);
  endtask

  // Leave tvalid high after the beat so the next point can follow at once.
  task automatic send_point(logic [71:0] pt);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= pt;
    do @(posedge clk); while (!s_tready);
    board.note_point(pt);
  endtask

  // Drop tvalid and let the pipe drain, including beats that will be dropped.
  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(3))
      0: return 24'($urandom_range(4095)) - 24'd2048;
      1: return 24'($urandom_range(65535));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(3))
      0: return 32'($urandom_range(131071)) - 32'd65536;
      1: return 32'($urandom_range(2000));
      default: return $urandom;
    endcase
  endfunction

  // Camera-like matrix: u and v from x,y over z, depth from z; also sets the image size.
  task automatic camera_matrix(logic [13:0] w, logic [13:0] h);
    write_reg(REG_ROW0_AB, {32'd0, 32'h0010_0000});
    write_reg(REG_ROW0_CD, {32'($urandom_range(600) << 16), 32'($urandom_range(65536))});
    write_reg(REG_ROW1_AB, {32'h0010_0000, 32'd0});
    write_reg(REG_ROW1_CD, {32'($urandom_range(600) << 16), 32'($urandom_range(65536))});
    write_reg(REG_ROW2_AB, 64'd0);
    write_reg(REG_ROW2_CD, {32'd0, 32'h0001_0000});
    write_reg(REG_WIDTH, 64'(w));
    write_reg(REG_HEIGHT, 64'(h));
  endtask

  task automatic random_matrix();
    write_reg(REG_ROW0_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW0_CD, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW1_CD, {rand_coef(), rand_coef()});
    write_reg(REG_ROW2_AB, {rand_coef(), rand_coef()});
    write_reg(REG_ROW2_CD, {rand_coef(), rand_coef()});
  endtask

  task automatic random_points(int count);
    logic [23:0] x, y, z;
    for (int i = 0; i < count; i++) begin
      x = rand_coord();
      y = rand_coord();
      z = $urandom_range(3) == 0 ? rand_coord() : 24'($urandom_range(20000));
      send_point({z, y, x});
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: identity-like unfiltered, extremes, zero and negative depth.
    write_reg(REG_ROW0_AB, {32'd0, 32'h0001_0000});
    write_reg(REG_ROW0_CD, 64'd0);
    write_reg(REG_ROW1_AB, {32'h0001_0000, 32'd0});
    write_reg(REG_ROW1_CD, 64'd0);
    write_reg(REG_ROW2_AB, 64'd0);
    write_reg(REG_ROW2_CD, {32'd0, 32'h0001_0000});
    write_reg(REG_WIDTH, 64'd0);
    write_reg(REG_HEIGHT, 64'd0);
    send_point({24'h000100, 24'h000200, 24'h000300});
    send_point({24'hFFFF00, 24'h7FFFFF, 24'h800000});
    send_point({24'h800000, 24'h800000, 24'h7FFFFF});
    send_point({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    send_point({24'h000000, 24'h000000, 24'h000000});
    send_point({24'h000000, 24'h000100, 24'hFFFF00});
    send_point({24'h000001, 24'hFFFFFF, 24'h000001});
    drain();
    write_reg(REG_ROW2_CD, 64'd0);
    write_reg(REG_ROW0_AB, {32'h8000_0000, 32'h7FFF_FFFF});
    write_reg(REG_ROW2_AB, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    send_point({24'h800000, 24'h800000, 24'h800000});
    send_point({24'h000000, 24'h000000, 24'h000000});
    drain();
    // Edges included: width 8192, height 1, largest size 16383.
    write_reg(REG_ROW2_AB, 64'd0);
    write_reg(REG_ROW0_AB, {32'd0, 32'h0001_0000});
    write_reg(REG_ROW2_CD, {32'd0, 32'h0001_0000});
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd1);
    send_point({24'h000100, 24'h000100, 24'h200000});
    send_point({24'h000100, 24'h000101, 24'h000000});
    send_point({24'h000100, 24'h000000, 24'h200001});
    send_point({24'hFFFF00, 24'h000000, 24'h000000});
    send_point({24'h000100, 24'hFFFFFF, 24'h000000});
    drain();
    write_reg(REG_WIDTH, 64'd16383);
    write_reg(REG_HEIGHT, 64'h3FFF);
    send_point({24'h000100, 24'h3FFF00, 24'h3FFF00});
    send_point({24'h000100, 24'h3FFF01, 24'h000000});
    drain();

    // Random phases over several settings and idling mixes.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase % 2 == 0) camera_matrix(14'($urandom_range(1, 1920)),
                                        14'($urandom_range(1, 1080)));
      else begin
        random_matrix();
        write_reg(REG_WIDTH, $urandom_range(1) ? 64'd0 : 64'($urandom_range(16383)));
        write_reg(REG_HEIGHT, 64'($urandom_range(16383)));
      end
      if (phase == 4) begin
        // Keep every point so the held-off output backs up the whole pipe.
        write_reg(REG_WIDTH, 64'd0);
        // Long receiver hold-off while points keep coming.
        fork
          begin
            hold_off = 1;
            for (int c = 0; c < 300; c++) @(posedge clk);
            hold_off = 0;
          end
          random_points(85);
        join
      end else random_points(85);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
